>>> design/mdr_pkg.sv
// ----------------------------------------------------------------------------
// mdr_pkg
// Shared types and constants for the high-multiply / divide / remainder unit.
// ----------------------------------------------------------------------------
package mdr_pkg;

	localparam int XLEN      = 64;
	localparam int HALF      = 32;
	localparam int DIV_STEPS = XLEN;

	localparam logic [XLEN-1:0] INT_MIN  = {1'b1, {(XLEN-1){1'b0}}};
	localparam logic [XLEN-1:0] ALL_ONES = {XLEN{1'b1}};

	typedef enum logic [2:0] {
		OP_MULHU  = 3'd0,
		OP_MULH   = 3'd1,
		OP_MULHSU = 3'd2,
		OP_DIV    = 3'd3,
		OP_REM    = 3'd4
	} op_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t             op;
		logic            special;
		logic [XLEN-1:0] spec_val;
		logic            neg;
		logic [XLEN-1:0] a_val;
		logic [XLEN-1:0] b_val;
	} item_t;

	// one divider pipeline slot
	typedef struct packed {
		op_t             op;
		logic            special;
		logic [XLEN-1:0] spec_val;
		logic            neg;
		logic [XLEN-1:0] rem;
		logic [XLEN-1:0] quo;
		logic [XLEN-1:0] dvs;
	} slot_t;

	typedef struct packed {
		logic [XLEN-1:0] p00;
		logic [XLEN-1:0] p01;
		logic [XLEN-1:0] p10;
		logic [XLEN-1:0] p11;
		logic [XLEN-1:0] corr;
	} mul_t;

endpackage

>>> design/mdr_req_if.sv
// ----------------------------------------------------------------------------
// mdr_req_if
// Request channel: operation and two operands with valid/ready.
// ----------------------------------------------------------------------------
interface mdr_req_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               operation;
	logic [mdr_pkg::XLEN-1:0] operand_a;
	logic [mdr_pkg::XLEN-1:0] operand_b;

	modport source (output valid, output operation, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input operation, input operand_a, input operand_b,
		output ready);
endinterface

>>> design/mdr_rsp_if.sv
// ----------------------------------------------------------------------------
// mdr_rsp_if
// Response channel: one 64-bit result with valid/ready.
// ----------------------------------------------------------------------------
interface mdr_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [mdr_pkg::XLEN-1:0] result_value;

	modport source (output valid, output result_value, input ready);
	modport sink (input valid, input result_value, output ready);
endinterface

>>> design/mdr_front.sv
// ----------------------------------------------------------------------------
// mdr_front
// Accepts requests, decodes the operation, takes operand magnitudes for
// divide/remainder and resolves the special cases up front.
// ----------------------------------------------------------------------------
module mdr_front (
	mdr_req_if.sink         req,
	output logic            push,
	input  logic            push_ready,
	output mdr_pkg::item_t  item
);

	logic                     a_neg;
	logic                     b_neg;
	logic                     is_div;
	logic                     b_zero;
	logic                     ovf;
	logic [mdr_pkg::XLEN-1:0] mag_a;
	logic [mdr_pkg::XLEN-1:0] mag_b;
	mdr_pkg::op_t             op;

	assign push      = req.valid;
	assign req.ready = push_ready;

	always_comb begin
		op     = mdr_pkg::op_t'(req.operation);
		a_neg  = req.operand_a[mdr_pkg::XLEN-1];
		b_neg  = req.operand_b[mdr_pkg::XLEN-1];
		mag_a  = a_neg ? (~req.operand_a + 1'b1) : req.operand_a;
		mag_b  = b_neg ? (~req.operand_b + 1'b1) : req.operand_b;
		is_div = (op == mdr_pkg::OP_DIV) || (op == mdr_pkg::OP_REM);
		b_zero = (req.operand_b == '0);
		ovf    = (req.operand_a == mdr_pkg::INT_MIN) && (req.operand_b == mdr_pkg::ALL_ONES);

		item.op       = op;
		item.special  = 1'b0;
		item.spec_val = '0;
		item.neg      = (op == mdr_pkg::OP_DIV) ? (a_neg ^ b_neg) : a_neg;
		item.a_val    = is_div ? mag_a : req.operand_a;
		item.b_val    = is_div ? mag_b : req.operand_b;

		priority if (req.operation > 3'(mdr_pkg::OP_REM)) begin
			item.special  = 1'b1;
			item.spec_val = '0;
		end else if (is_div && b_zero) begin
			item.special  = 1'b1;
			item.spec_val = (op == mdr_pkg::OP_DIV) ? mdr_pkg::ALL_ONES : req.operand_a;
		end else if (is_div && ovf) begin
			item.special  = 1'b1;
			item.spec_val = (op == mdr_pkg::OP_DIV) ? mdr_pkg::INT_MIN : '0;
		end else begin
			item.special  = 1'b0;
		end
	end

endmodule

>>> design/mdr_queue.sv
// ----------------------------------------------------------------------------
// mdr_queue
// Two-entry item queue between front and back.
// ----------------------------------------------------------------------------
module mdr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  mdr_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mdr_pkg::item_t pop_item
);

	mdr_pkg::item_t slot_q [0:1];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> design/mdr_back.sv
// ----------------------------------------------------------------------------
// mdr_back
// Execution pipeline: 64 restoring-division stages, a two-stage multiply
// lane that merges into stage 2, and a result register.
// ----------------------------------------------------------------------------
module mdr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mdr_pkg::item_t in_item,
	mdr_rsp_if.source      rsp
);

	localparam int N = mdr_pkg::DIV_STEPS;
	localparam int W = mdr_pkg::XLEN;
	localparam int H = mdr_pkg::HALF;

	logic                vld_q  [0:N];
	mdr_pkg::slot_t      pipe_q [0:N];
	mdr_pkg::slot_t      pipe_d [1:N];
	mdr_pkg::mul_t       mul_s1;
	logic [W-1:0]        mul_hi;
	logic [H+1:0]        mid;
	logic                en;
	logic                out_valid_q;
	logic [W-1:0]        out_data_q;
	logic [W-1:0]        fin;

	function automatic mdr_pkg::slot_t div_step(input mdr_pkg::slot_t s);
		mdr_pkg::slot_t r;
		logic [W:0]     t;
		logic [W+1:0]   diff;
		r    = s;
		t    = {s.rem, s.quo[W-1]};
		diff = {1'b0, t} - {2'b00, s.dvs};
		if ((s.op == mdr_pkg::OP_DIV) || (s.op == mdr_pkg::OP_REM)) begin
			r.rem = diff[W+1] ? t[W-1:0] : diff[W-1:0];
			r.quo = {s.quo[W-2:0], ~diff[W+1]};
		end
		return r;
	endfunction

	// pipeline advances whenever the result register is free or drains
	assign en       = !out_valid_q || rsp.ready;
	assign in_ready = en;

	always_comb begin
		mid = {2'b00, mul_s1.p00[W-1:H]} + {2'b00, mul_s1.p10[H-1:0]}
			+ {2'b00, mul_s1.p01[H-1:0]};
		mul_hi = mul_s1.p11 + {{H{1'b0}}, mul_s1.p10[W-1:H]}
			+ {{H{1'b0}}, mul_s1.p01[W-1:H]} + {{(W-2){1'b0}}, mid[H+1:H]} - mul_s1.corr;
		for (int i = 1; i <= N; i++) begin
			pipe_d[i] = div_step(pipe_q[i-1]);
		end
		// multiply result joins the slot as it enters stage 2
		if ((pipe_q[1].op == mdr_pkg::OP_MULHU) || (pipe_q[1].op == mdr_pkg::OP_MULH)
			|| (pipe_q[1].op == mdr_pkg::OP_MULHSU)) begin
			pipe_d[2].quo = mul_hi;
		end
	end

	always_comb begin
		unique case (pipe_q[N].op)
			mdr_pkg::OP_DIV: fin = pipe_q[N].neg ? (~pipe_q[N].quo + 1'b1) : pipe_q[N].quo;
			mdr_pkg::OP_REM: fin = pipe_q[N].neg ? (~pipe_q[N].rem + 1'b1) : pipe_q[N].rem;
			default:         fin = pipe_q[N].quo;
		endcase
		if (pipe_q[N].special) fin = pipe_q[N].spec_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= N; i++) vld_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i <= N; i++) vld_q[i] <= vld_q[i-1];
			out_valid_q <= vld_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0].op       <= in_item.op;
			pipe_q[0].special  <= in_item.special;
			pipe_q[0].spec_val <= in_item.spec_val;
			pipe_q[0].neg      <= in_item.neg;
			pipe_q[0].rem      <= '0;
			pipe_q[0].quo      <= in_item.a_val;
			pipe_q[0].dvs      <= in_item.b_val;
			for (int i = 1; i <= N; i++) pipe_q[i] <= pipe_d[i];
			mul_s1.p00  <= W'(pipe_q[0].quo[H-1:0]) * W'(pipe_q[0].dvs[H-1:0]);
			mul_s1.p01  <= W'(pipe_q[0].quo[H-1:0]) * W'(pipe_q[0].dvs[W-1:H]);
			mul_s1.p10  <= W'(pipe_q[0].quo[W-1:H]) * W'(pipe_q[0].dvs[H-1:0]);
			mul_s1.p11  <= W'(pipe_q[0].quo[W-1:H]) * W'(pipe_q[0].dvs[W-1:H]);
			mul_s1.corr <= (((pipe_q[0].op != mdr_pkg::OP_MULHU) && pipe_q[0].quo[W-1])
					? pipe_q[0].dvs : '0)
				+ (((pipe_q[0].op == mdr_pkg::OP_MULH) && pipe_q[0].dvs[W-1])
					? pipe_q[0].quo : '0);
			out_data_q  <= fin;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_data_q;

`ifndef SYNTHESIS
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_q[N] |=> out_valid_q)
		else $error("last stage item not moved to result register");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q[N]) && $stable(out_data_q))
		else $error("pipeline moved during stall");
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_q[N]))
		else $error("result appeared without an item");
`endif

endmodule

>>> design/rv64_mulh_div_rem_unit.sv
// ----------------------------------------------------------------------------
// rv64_mulh_div_rem_unit
// RV64 high multiply, signed divide and signed remainder unit.
// ----------------------------------------------------------------------------
// path from request accept to result valid: queue entry, pipeline entry,
// 64 division stages, result register. Throughput: one item per cycle
// unless a response stall holds the pipeline, set by the fully pipelined
// divider; multiplies ride the same pipeline so results leave in order
// reset clears all valid bits; no result is pending after reset
module rv64_mulh_div_rem_unit (
	input  logic       clk,
	input  logic       arst_n,
	mdr_req_if.sink    req,
	mdr_rsp_if.source  rsp
);

	logic           push;
	logic           push_ready;
	mdr_pkg::item_t push_item;
	logic           pop_valid;
	logic           pop_ready;
	mdr_pkg::item_t pop_item;

	mdr_front u_front (
		.req        (req),
		.push       (push),
		.push_ready (push_ready),
		.item       (push_item)
	);

	mdr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mdr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop_valid),
		.in_ready (pop_ready),
		.in_item  (pop_item),
		.rsp      (rsp)
	);

endmodule
